>>> rtl/core/esss_pkg.sv
// Shared types, register indexes and sizes for the exact substring search unit.
package esss_pkg;

  // Needle storage held in configuration: four 64-bit words of eight bytes
  localparam int NEEDLE_WORDS = 4;
  localparam int NEEDLE_BYTES = 8 * NEEDLE_WORDS;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int LEN_W        = 6;
  localparam int START_W      = 32;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LEN  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LOW  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_MID  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_HIGH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_TOP  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SCAN_EVERY  = 3'd5;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } esss_in_t;

  typedef struct packed {
    logic               match_found;
    logic [START_W-1:0] match_start;
    logic               search_done;
    logic               count_overflow;
  } esss_out_t;

  // Needle and mode as seen by the datapath
  typedef struct packed {
    logic [NEEDLE_BYTES-1:0][7:0] needle;
    logic                         scan_every;
  } esss_cfg_t;

endpackage

>>> rtl/core/esss_cfg_regs.sv
// Configuration registers and the clamped needle length.
module esss_cfg_regs import esss_pkg::*; #(
  parameter int MAX_NEEDLE = 32,
  parameter int NLEN_W     = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output esss_cfg_t              cfg,
  output logic [NLEN_W-1:0]      needle_len
);

  logic [LEN_W-1:0]                          len_r;
  logic [NEEDLE_WORDS-1:0][CFG_DATA_W-1:0]   words_r;
  logic                                      scan_r;

  // Capture register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= LEN_W'(1);
      words_r <= '0;
      scan_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NEEDLE_LEN:  len_r      <= cfg_wdata[LEN_W-1:0];
        REG_NEEDLE_LOW:  words_r[0] <= cfg_wdata;
        REG_NEEDLE_MID:  words_r[1] <= cfg_wdata;
        REG_NEEDLE_HIGH: words_r[2] <= cfg_wdata;
        REG_NEEDLE_TOP:  words_r[3] <= cfg_wdata;
        REG_SCAN_EVERY:  scan_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Clamp the length to 1..MAX_NEEDLE
  always_comb begin
    if (len_r == '0) begin
      needle_len = NLEN_W'(1);
    end else if ({1'b0, len_r} > (LEN_W+1)'(MAX_NEEDLE)) begin
      needle_len = NLEN_W'(MAX_NEEDLE);
    end else begin
      needle_len = NLEN_W'(len_r);
    end
  end

  assign cfg.needle     = words_r;
  assign cfg.scan_every = scan_r;

endmodule

>>> rtl/core/esss_window_cmp.sv
// Byte window shift line and parallel needle compare.
module esss_window_cmp import esss_pkg::*; #(
  parameter int MAX_NEEDLE = 32,
  parameter int NLEN_W     = 6
) (
  input  logic                          clk,
  input  logic                          shift_en,
  input  logic [7:0]                    text_byte,
  input  logic [NEEDLE_BYTES-1:0][7:0]  needle,
  input  logic [NLEN_W-1:0]             needle_len,
  output logic                          window_hit
);

  // Entry 0 is the newest byte. Entries older than the search start are
  // never compared, so the window needs no reset or clear.
  logic [7:0] win_r   [MAX_NEEDLE];
  logic [7:0] win_new [MAX_NEEDLE];
  logic [MAX_NEEDLE-1:0] pos_ok;

  assign win_new[0] = text_byte;

  for (genvar k = 1; k < MAX_NEEDLE; k++) begin : g_shift
    assign win_new[k] = win_r[k-1];
  end

  // Advance the window on each processed byte
  always_ff @(posedge clk) begin
    if (shift_en) begin
      win_r <= win_new;
    end
  end

  // Compare window entry k with needle byte (len-1-k); unused positions pass
  for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_cmp
    logic       in_use;
    logic [7:0] want;
    logic [7:0] sel;
    assign in_use = (8'(needle_len) > 8'(k));
    assign sel    = 8'(needle_len) - 8'(k) - 8'd1;
    assign want   = (sel < 8'(NEEDLE_BYTES)) ? needle[sel[4:0]] : 8'd0;
    assign pos_ok[k] = !in_use || (win_new[k] == want);
  end

  assign window_hit = &pos_ok;

endmodule

>>> rtl/core/exact_substring_search_unit.sv
// Top level: input stage, search state, result register and handshakes.
// An accepted byte waits in the input stage; when it moves on, its result, if it
// has one, is loaded into the result register and offered from there.
// Throughput: one byte per cycle unless a stalled full result register holds
// the input stage; window compare and index update happen between the stages.
// Reset (rst_n low, synchronous) empties both stages, clears the byte index,
// match state and overflow flag, and restores needle length 1, zero needle
// bytes and first-only mode.
module exact_substring_search_unit import esss_pkg::*; #(
  parameter int MAX_NEEDLE = 32,
  parameter int INDEX_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  esss_in_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output esss_out_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int NLEN_W = $clog2(MAX_NEEDLE + 1);
  localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;
  localparam logic [NLEN_W-1:0]     ELIG_MAX  = NLEN_W'(MAX_NEEDLE);

  esss_cfg_t          cfg;
  logic [NLEN_W-1:0]  needle_len;

  logic               s1_valid_r, s1_valid_nxt;
  esss_in_t           s1_data_r;
  logic               advance;
  logic               in_accept;

  logic [INDEX_BITS-1:0] count_r, count_nxt, count_inc;
  logic [NLEN_W-1:0]     elig_r, elig_nxt, elig_inc;
  logic                  first_r, first_nxt;
  logic                  ovf_r, ovf_nxt, ovf_now;
  logic [INDEX_BITS-1:0] idx;
  logic [INDEX_BITS-1:0] start_full;
  logic                  window_hit;
  logic                  hit;
  logic                  has_result;

  logic                  out_valid_r, out_valid_nxt;
  esss_out_t             out_data_r, out_data_nxt;

  esss_cfg_regs #(
    .MAX_NEEDLE (MAX_NEEDLE),
    .NLEN_W     (NLEN_W)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cfg        (cfg),
    .needle_len (needle_len)
  );

  esss_window_cmp #(
    .MAX_NEEDLE (MAX_NEEDLE),
    .NLEN_W     (NLEN_W)
  ) u_win (
    .clk        (clk),
    .shift_en   (advance),
    .text_byte  (s1_data_r.text_byte),
    .needle     (cfg.needle),
    .needle_len (needle_len),
    .window_hit (window_hit)
  );

  // Handshake: the input stage moves on when the result register is free
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
  end

  // Byte index with saturation
  always_comb begin
    if (count_r == INDEX_MAX) begin
      idx       = INDEX_MAX;
      ovf_now   = 1'b1;
      count_inc = count_r;
    end else begin
      idx       = count_r;
      ovf_now   = ovf_r;
      count_inc = count_r + INDEX_BITS'(1);
    end
  end

  // Eligibility count and match decision
  assign elig_inc   = (elig_r < ELIG_MAX) ? elig_r + NLEN_W'(1) : elig_r;
  assign hit        = (elig_inc >= needle_len) && (cfg.scan_every || !first_r) && window_hit;
  assign start_full = idx - INDEX_BITS'(needle_len - NLEN_W'(1));
  assign has_result = hit || s1_data_r.text_end;

  // Next search state; the last byte returns everything to the start
  always_comb begin
    count_nxt = count_inc;
    elig_nxt  = hit ? '0 : elig_inc;
    first_nxt = first_r || hit;
    ovf_nxt   = ovf_now;
    if (s1_data_r.text_end) begin
      elig_nxt  = '0;
      first_nxt = 1'b0;
      ovf_nxt   = 1'b0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      elig_r  <= '0;
      first_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else if (advance) begin
      count_r <= count_nxt;
      elig_r  <= elig_nxt;
      first_r <= first_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Build the result item
  always_comb begin
    out_data_nxt.match_found    = hit;
    out_data_nxt.match_start    = hit ? START_W'(start_full) : '0;
    out_data_nxt.search_done    = s1_data_r.text_end;
    out_data_nxt.count_overflow = ovf_now;
  end

  // Result register: load on a processed byte with a result, drop on transfer
  assign out_valid_nxt = advance ? has_result : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Eligibility count never passes its saturation point
  assert property (@(posedge clk) disable iff (!rst_n) elig_r <= ELIG_MAX)
    else $error("eligibility count above needle limit");

  // A processed last byte leaves the search state at its start
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_data_r.text_end |=> count_r == '0 && elig_r == '0 && !first_r && !ovf_r)
    else $error("search state not cleared after last byte");

  // A reported match restarts the eligibility count
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && hit && !s1_data_r.text_end |=> elig_r == '0 && first_r)
    else $error("match did not restart the search window");

  // A result held under stall blocks the input stage only when it is full
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && s1_valid_r |-> in_stall && !advance)
    else $error("input stage advanced into a stalled result register");

endmodule
